/* hdl/vnu_pkg.sv */
package vnu_pkg;

    localparam int COMPONENT_WIDTH_DEF = 24;
    localparam int FRACTION_BITS_DEF   = 16;
    localparam int NUM_LANES           = 3;

endpackage

/* hdl/vec3_normalize_unit_top.sv */
// Stage order: magnitude and sign, squares, sum of squares, square root, divide, output.
// Throughput: one item per cycle; a new item enters every cycle unless the output stalls.
// The pipeline is a root stage per magnitude bit and a divide stage per quotient bit.
// A stall on m_ready freezes every stage together.
// aresetn (synchronous, active low) clears all valid bits; payload registers are not reset.
module vec3_normalize_unit_top
    import vnu_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] s_x_in,
    input  logic signed [COMPONENT_WIDTH-1:0] s_y_in,
    input  logic signed [COMPONENT_WIDTH-1:0] s_z_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic        [COMPONENT_WIDTH-1:0] m_magnitude,
    output logic signed [FRACTION_BITS+1:0]   m_unit_x,
    output logic signed [FRACTION_BITS+1:0]   m_unit_y,
    output logic signed [FRACTION_BITS+1:0]   m_unit_z,
    output logic                              m_zero_vector
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int SW = 2 * CW;
    localparam int UW = FB + 2;
    localparam int NL = NUM_LANES;
    localparam int ND = FB + 1;

    logic en;
    logic ov_reg;

    assign en      = !ov_reg || m_ready;
    assign s_ready = en;

    // stage 0: magnitude and sign of each component
    logic [CW-1:0] a0_reg [NL];
    logic          n0_reg [NL];
    logic          v0_reg;
    logic signed [CW-1:0] in_comp [NL];

    assign in_comp[0] = s_x_in;
    assign in_comp[1] = s_y_in;
    assign in_comp[2] = s_z_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                n0_reg[l] <= in_comp[l][CW-1];
                a0_reg[l] <= in_comp[l][CW-1] ? CW'(-in_comp[l]) : CW'(in_comp[l]);
            end
        end
    end

    // stage 1: squares
    logic [SW-1:0] sq1_reg [NL];
    logic [CW-1:0] a1_reg  [NL];
    logic          n1_reg  [NL];
    logic          v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                sq1_reg[l] <= SW'(a0_reg[l]) * SW'(a0_reg[l]);
                a1_reg[l]  <= a0_reg[l];
                n1_reg[l]  <= n0_reg[l];
            end
        end
    end

    // stage 2: sum of squares
    logic [SW-1:0] sum2_reg;
    logic [CW-1:0] a2_reg [NL];
    logic          n2_reg [NL];
    logic          v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            a2_reg   <= a1_reg;
            n2_reg   <= n1_reg;
        end
    end

    // square root, one result bit per stage
    logic [SW-1:0] rad_reg  [CW];
    logic [CW:0]   rrem_reg [CW];
    logic [CW-1:0] root_reg [CW];
    logic [CW-1:0] ra_reg   [CW][NL];
    logic          rn_reg   [CW][NL];
    logic          rv_reg   [CW];

    for (genvar k = 0; k < CW; k++) begin : g_root
        logic [SW-1:0] rad_i;
        logic [CW:0]   rem_i;
        logic [CW-1:0] root_i;
        logic [CW-1:0] a_i [NL];
        logic          n_i [NL];
        logic          v_i;
        logic [CW+2:0] cur;
        logic [CW+2:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rad_i  = sum2_reg;
            assign rem_i  = '0;
            assign root_i = '0;
            assign a_i    = a2_reg;
            assign n_i    = n2_reg;
            assign v_i    = v2_reg;
        end else begin : g_next
            assign rad_i  = rad_reg[k-1];
            assign rem_i  = rrem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign a_i    = ra_reg[k-1];
            assign n_i    = rn_reg[k-1];
            assign v_i    = rv_reg[k-1];
        end

        assign cur   = {rem_i, rad_i[SW-1 -: 2]};
        assign trial = {1'b0, root_i, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv_reg[k] <= 1'b0;
            end else if (en) begin
                rv_reg[k] <= v_i;
            end
            if (en) begin
                rad_reg[k]  <= {rad_i[SW-3:0], 2'b00};
                rrem_reg[k] <= ge ? (CW+1)'(cur - trial) : (CW+1)'(cur);
                root_reg[k] <= {root_i[CW-2:0], ge};
                ra_reg[k]   <= a_i;
                rn_reg[k]   <= n_i;
            end
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    logic [CW-1:0] dmag_reg [ND];
    logic [CW:0]   drem_reg [ND][NL];
    logic [FB:0]   dq_reg   [ND][NL];
    logic          dn_reg   [ND][NL];
    logic          dv_reg   [ND];

    for (genvar j = 0; j < ND; j++) begin : g_div
        logic [CW-1:0] mag_i;
        logic [CW:0]   rem_i [NL];
        logic [FB:0]   q_i   [NL];
        logic          n_i   [NL];
        logic          v_i;

        if (j == 0) begin : g_first
            assign mag_i = root_reg[CW-1];
            assign n_i   = rn_reg[CW-1];
            assign v_i   = rv_reg[CW-1];
            for (genvar l = 0; l < NL; l++) begin : g_ln
                assign rem_i[l] = {1'b0, ra_reg[CW-1][l]};
                assign q_i[l]   = '0;
            end
        end else begin : g_next
            assign mag_i = dmag_reg[j-1];
            assign n_i   = dn_reg[j-1];
            assign v_i   = dv_reg[j-1];
            assign rem_i = drem_reg[j-1];
            assign q_i   = dq_reg[j-1];
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic [CW+1:0] cur;
            logic          ge;

            assign cur = (j == 0) ? {1'b0, rem_i[l]} : {rem_i[l], 1'b0};
            assign ge  = cur >= {2'b00, mag_i};

            always_ff @(posedge aclk) begin
                if (en) begin
                    drem_reg[j][l] <= ge ? (CW+1)'(cur - {2'b00, mag_i}) : (CW+1)'(cur);
                    dq_reg[j][l]   <= {q_i[l][FB-1:0], ge};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j] <= 1'b0;
            end else if (en) begin
                dv_reg[j] <= v_i;
            end
            if (en) begin
                dmag_reg[j] <= mag_i;
                dn_reg[j]   <= n_i;
            end
        end
    end

    // output register: clamp, sign, zero vector
    localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

    logic [CW-1:0]        mag_out_reg;
    logic signed [UW-1:0] unit_out_reg [NL];
    logic                 zero_out_reg;
    logic signed [UW-1:0] unit_next    [NL];
    logic                 zero_next;

    assign zero_next = (dmag_reg[ND-1] == '0);

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            logic [FB:0] qc;
            qc = (dq_reg[ND-1][l] > ONE) ? ONE : dq_reg[ND-1][l];
            if (zero_next) begin
                unit_next[l] = '0;
            end else if (dn_reg[ND-1][l]) begin
                unit_next[l] = -$signed({1'b0, qc});
            end else begin
                unit_next[l] = $signed({1'b0, qc});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= dv_reg[ND-1];
        end
        if (en) begin
            mag_out_reg  <= dmag_reg[ND-1];
            unit_out_reg <= unit_next;
            zero_out_reg <= zero_next;
        end
    end

    assign m_valid       = ov_reg;
    assign m_magnitude   = mag_out_reg;
    assign m_unit_x      = unit_out_reg[0];
    assign m_unit_y      = unit_out_reg[1];
    assign m_unit_z      = unit_out_reg[2];
    assign m_zero_vector = zero_out_reg;

endmodule

/* hdl/vnu_checker.sv */
module vnu_checker
    import vnu_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic        [COMPONENT_WIDTH-1:0] m_magnitude,
    input logic signed [FRACTION_BITS+1:0]   m_unit_x,
    input logic signed [FRACTION_BITS+1:0]   m_unit_y,
    input logic signed [FRACTION_BITS+1:0]   m_unit_z,
    input logic                              m_zero_vector
);

    localparam logic signed [FRACTION_BITS+1:0] ONE = (FRACTION_BITS+2)'(1) << FRACTION_BITS;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_magnitude) && $stable(m_unit_x))
        else $error("result item changed while stalled");

    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_zero_vector == (m_magnitude == '0)))
        else $error("zero flag disagrees with magnitude");

    a_zero_units: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_vector |-> m_unit_x == '0 && m_unit_y == '0 && m_unit_z == '0)
        else $error("zero vector with nonzero unit components");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_unit_x <= ONE && m_unit_x >= -ONE && m_unit_y <= ONE
            && m_unit_y >= -ONE && m_unit_z <= ONE && m_unit_z >= -ONE)
        else $error("unit component out of range");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready inconsistent with output stall");

endmodule

bind vec3_normalize_unit_top vnu_checker #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH),
    .FRACTION_BITS  (FRACTION_BITS)
) u_vnu_checker (.*);

/* dv/tb_vec3_normalize_unit_top.sv */
module tb_vec3_normalize_unit_top
    import vnu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COMPONENT_WIDTH_DEF;
    localparam int FB = FRACTION_BITS_DEF;
    localparam int UW = FB + 2;
    localparam int LATENCY = CW + FB + 5;
    localparam int N_RANDOM = 1900;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CW-1:0] magnitude;
        logic [UW-1:0] unit_x;
        logic [UW-1:0] unit_y;
        logic [UW-1:0] unit_z;
        logic          zero_vector;
    } norm_t;

    class norm_scoreboard;
        norm_t pending[$];
        int errors;

        function automatic longint unsigned isqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function automatic logic [UW-1:0] unit_comp(longint unsigned a, bit neg,
                                                    longint unsigned mag);
            longint unsigned q;
            longint unsigned one;
            one = 64'd1 << FB;
            q = (a << FB) / mag;
            if (q > one) q = one;
            if (neg) q = ~q + 1;
            return q[UW-1:0];
        endfunction

        function automatic void note_vector(logic [CW-1:0] x, logic [CW-1:0] y,
                                            logic [CW-1:0] z);
            longint unsigned ax, ay, az, mag;
            norm_t e;
            ax = x[CW-1] ? longint'((~x + 1'b1) & {CW{1'b1}}) : longint'(x);
            ay = y[CW-1] ? longint'((~y + 1'b1) & {CW{1'b1}}) : longint'(y);
            az = z[CW-1] ? longint'((~z + 1'b1) & {CW{1'b1}}) : longint'(z);
            mag = isqrt(ax * ax + ay * ay + az * az);
            e = '0;
            if (mag == 0) begin
                e.zero_vector = 1'b1;
            end else begin
                e.magnitude = mag[CW-1:0];
                e.unit_x = unit_comp(ax, x[CW-1], mag);
                e.unit_y = unit_comp(ay, y[CW-1], mag);
                e.unit_z = unit_comp(az, z[CW-1], mag);
            end
            pending.push_back(e);
        endfunction

        function automatic void check_result(norm_t got);
            norm_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item mag=%h", $time, got.magnitude);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.magnitude !== e.magnitude) begin
                $display("%0t: magnitude exp %h got %h", $time, e.magnitude, got.magnitude);
                errors++;
            end
            if (got.unit_x !== e.unit_x) begin
                $display("%0t: unit_x exp %h got %h", $time, e.unit_x, got.unit_x);
                errors++;
            end
            if (got.unit_y !== e.unit_y) begin
                $display("%0t: unit_y exp %h got %h", $time, e.unit_y, got.unit_y);
                errors++;
            end
            if (got.unit_z !== e.unit_z) begin
                $display("%0t: unit_z exp %h got %h", $time, e.unit_z, got.unit_z);
                errors++;
            end
            if (got.zero_vector !== e.zero_vector) begin
                $display("%0t: zero_vector exp %b got %b", $time, e.zero_vector,
                         got.zero_vector);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_x_in = '0;
    logic signed [CW-1:0] s_y_in = '0;
    logic signed [CW-1:0] s_z_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CW-1:0] m_magnitude;
    logic signed [UW-1:0] m_unit_x, m_unit_y, m_unit_z;
    logic m_zero_vector;

    norm_scoreboard sb = new();
    longint cycles = 0;
    bit stall_mode = 0;

    vec3_normalize_unit_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_x_in(s_x_in), .s_y_in(s_y_in), .s_z_in(s_z_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_magnitude(m_magnitude), .m_unit_x(m_unit_x), .m_unit_y(m_unit_y),
        .m_unit_z(m_unit_z), .m_zero_vector(m_zero_vector)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (aresetn && s_valid && s_ready) sb.note_vector(s_x_in, s_y_in, s_z_in);
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_magnitude, m_unit_x, m_unit_y, m_unit_z, m_zero_vector});
    end

    // receiver stall pattern: long open stretches alternate with choppy ones
    always @(negedge aclk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
        if (!stall_mode) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        s_valid <= 1'b1;
        s_x_in <= x;
        s_y_in <= y;
        s_z_in <= z;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic idle_gap(int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return {1'b0, {(CW-1){1'b1}}};
            3: return CW'($signed($urandom_range(0, 512)) - 256);
            default: return CW'($urandom);
        endcase
    endfunction

    localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE = CW'(1) << FB;
    localparam logic [CW-1:0] NEG1 = '1;

    initial begin
        int sent;
        int burst;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: zero vector, axes, extremes, tiny values, 3-4-5 triples
        send_vector('0, '0, '0);
        send_vector(ONE, '0, '0);
        send_vector('0, -ONE, '0);
        send_vector('0, '0, ONE);
        send_vector(MAXP, MAXP, MAXP);
        send_vector(MINN, MINN, MINN);
        send_vector(MINN, '0, '0);
        send_vector(MAXP, MINN, MAXP);
        send_vector(CW'(1), '0, '0);
        send_vector(NEG1, NEG1, NEG1);
        send_vector(CW'(1), CW'(1), CW'(1));
        send_vector(CW'(3), CW'(4), '0);
        send_vector(-CW'(3), '0, CW'(4));
        send_vector(CW'(2), CW'(3), CW'(6));
        send_vector(CW'(1), CW'(2), CW'(2));
        send_vector(CW'(1), CW'(1), '0);
        send_vector(MAXP, CW'(1), NEG1);
        send_vector(CW'(24'h555555), CW'(24'haaaaaa), CW'(24'h0f0f0f));
        idle_gap(3);

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_vector(rand_comp(), rand_comp(), rand_comp());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (sb.errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
